### rtl/core/wans_pkg.sv
// Package for the weekly alarm selector: word types, constants and small arithmetic helpers.
// It depends on nothing else. The cell and the top level use it through scoped names.
`default_nettype none

package wans_pkg;

   // Calendar constants.
   localparam int MIN_PER_HOUR  = 60;
   localparam int HOURS_PER_DAY = 24;
   localparam int DAYS_PER_WEEK = 7;
   localparam int MIN_PER_DAY   = 1440;

   // Search window: one more day than a week, tried from the current weekday.
   localparam int DAY_OFFSETS = 8;

   // Starting best distance, one minute more than a full week.
   localparam logic [13:0] CAND_NONE = 14'(DAYS_PER_WEEK * MIN_PER_DAY + 1);

   // Reset value of the wake-up duration in minutes.
   localparam logic [7:0] DUR_RESET = 8'd30;

   // Reset contents of every slot: 07:00 on all days.
   localparam logic [4:0] SLOT_HOUR_RESET = 5'd7;
   localparam logic [6:0] ALL_DAYS        = 7'h7F;

   typedef enum logic [1:0] {
      OP_WRITE   = 2'd0,
      OP_FIND    = 2'd1,
      OP_TRIGGER = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESPOND
   } state_type;

   // Request word.
   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] slot_index;
      logic [7:0] new_hour;
      logic [7:0] new_minute;
      logic       new_hidden;
      logic       new_enable;
      logic       new_repeat;
      logic [6:0] new_day_mask;
      logic [2:0] now_weekday;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
   } req_type;

   // Response word.
   typedef struct packed {
      logic       alarm_armed;
      logic [2:0] alarm_weekday;
      logic [4:0] alarm_hour;
      logic [5:0] alarm_minute;
      logic [4:0] end_hour;
      logic [5:0] end_minute;
      logic [2:0] chosen_slot;
   } rsp_type;

   // One stored alarm slot.
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic       hidden;
      logic       enable;
      logic       repeat_on;
      logic [6:0] day_mask;
   } slot_type;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic       wr_stb;
      logic       clr_stb;
      logic [2:0] addr;
      slot_type   wdata;
      logic [2:0] now_wday;
      logic [10:0] now_mins;
   } cell_ctl_type;

   // Best candidate so far, handed from cell to cell.
   typedef struct packed {
      logic        found;
      logic [13:0] cand;
      logic [2:0]  slot;
      logic [2:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } best_type;

   // Remainder of an 8-bit value by 24, through a reciprocal multiply.
   function automatic logic [4:0] mod24(input logic [7:0] v);
      logic [15:0] prod;
      logic [3:0]  q;
      logic [7:0]  r;
      prod = 16'(v) * 16'd171;
      q    = prod[15:12];
      r    = v - 8'(8'(q) * 8'd24);
      return r[4:0];
   endfunction

   // Quotient of a value below 320 by 60, through a reciprocal multiply.
   function automatic logic [2:0] div60(input logic [8:0] v);
      logic [19:0] prod;
      prod = 20'(v) * 20'd1093;
      return prod[18:16];
   endfunction

   // Remainder of a value below 320 by 60.
   function automatic logic [5:0] mod60(input logic [8:0] v);
      logic [8:0] r;
      r = v - 9'(9'(div60(v)) * 9'd60);
      return r[5:0];
   endfunction

   // Weekday a number of days after the given one, taken modulo 7.
   function automatic logic [2:0] day_after(input logic [2:0] wday, input logic [2:0] k);
      logic [3:0] s;
      s = 4'(wday) + 4'(k);
      if (s >= 4'(2 * DAYS_PER_WEEK)) begin
         s = s - 4'(2 * DAYS_PER_WEEK);
      end else if (s >= 4'(DAYS_PER_WEEK)) begin
         s = s - 4'(DAYS_PER_WEEK);
      end
      return s[2:0];
   endfunction

endpackage

`default_nettype wire

### rtl/core/wans_cell.sv
// One alarm slot cell: holds a slot, finds its first upcoming time and keeps the better candidate.
// Depends on wans_pkg. Instantiated in a row by weekly_alarm_next_selector_unit.
`default_nettype none

module wans_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wans_pkg::cell_ctl_type ctl,
   input  wire wans_pkg::best_type    best_in,
   output wans_pkg::best_type         best_out
);

   wans_pkg::slot_type slot_ff;
   wans_pkg::slot_type slot_in;
   wans_pkg::best_type best_ff;
   wans_pkg::best_type best_in_sel;

   logic               sel;
   logic [10:0]        slot_mins;
   logic signed [12:0] delta;
   logic               hit;
   logic [13:0]        pick_cand;
   logic [2:0]         pick_day;
   logic               take;

   assign sel = (32'(ctl.addr) == INDEX);

   // Slot update: a write stores the word, a trigger drops the enable of a one-shot slot.
   always_comb begin
      slot_in = slot_ff;
      if (ctl.wr_stb && sel) begin
         slot_in = ctl.wdata;
      end else if (ctl.clr_stb && sel && !slot_ff.repeat_on) begin
         slot_in.enable = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.hour      <= wans_pkg::SLOT_HOUR_RESET;
         slot_ff.minute    <= '0;
         slot_ff.hidden    <= 1'b1;
         slot_ff.enable    <= 1'b1;
         slot_ff.repeat_on <= 1'b1;
         slot_ff.day_mask  <= wans_pkg::ALL_DAYS;
      end else begin
         slot_ff <= slot_in;
      end
   end

   // Signed distance from now to the slot time on the same day.
   assign slot_mins = 11'(11'(slot_ff.hour) * 11'd60) + 11'(slot_ff.minute);
   assign delta     = $signed({2'b00, slot_mins}) - $signed({2'b00, ctl.now_mins});

   // First day offset that matches the mask (any day for a one-shot slot) and lies strictly ahead.
   always_comb begin
      logic signed [15:0] cand;
      logic               match;
      logic [2:0]         day;
      hit       = 1'b0;
      pick_cand = '0;
      pick_day  = '0;
      for (int k = wans_pkg::DAY_OFFSETS - 1; k >= 0; k--) begin
         day   = wans_pkg::day_after(ctl.now_wday, 3'(k));
         match = !slot_ff.repeat_on || slot_ff.day_mask[day];
         cand  = 16'(k * wans_pkg::MIN_PER_DAY) + 16'(delta);
         if (match && (cand > 16'sd0)) begin
            hit       = 1'b1;
            pick_cand = cand[13:0];
            pick_day  = day;
         end
      end
   end

   // Keep the incoming best unless this slot is strictly nearer; ties stay with the lower slot.
   assign take = !slot_ff.hidden && slot_ff.enable && hit && (pick_cand < best_in.cand);

   always_comb begin
      best_in_sel = best_in;
      if (take) begin
         best_in_sel.found  = 1'b1;
         best_in_sel.cand   = pick_cand;
         best_in_sel.slot   = 3'(INDEX);
         best_in_sel.day    = pick_day;
         best_in_sel.hour   = slot_ff.hour;
         best_in_sel.minute = slot_ff.minute;
      end
   end

   // The candidate moves one cell along the row each cycle.
   always_ff @(posedge clock) begin
      best_ff <= best_in_sel;
   end

   assign best_out = best_ff;

endmodule

`default_nettype wire

### rtl/core/weekly_alarm_next_selector_unit.sv
// Top level of the weekly alarm selector: command port, configuration register, cell row, results.
// Depends on wans_pkg and wans_cell.
//
//   channel   ports                          direction  transfer
//   request   start, busy, req_word          in         start high while busy low
//   response  rsp_valid, rsp_word            out        one-cycle strobe, no back-pressure
//   config    csr_valid, csr_ready, csr_wdata in        valid and ready both high
//
// A write or an unused operation answers in the cycle after acceptance.
// A find or trigger passes the candidate along the row of ALARM_SLOTS cells, one cell a cycle,
// then the result registers load and the response follows; the row length sets how long the search runs.
// busy holds until the response strobe has gone, so a new word is taken only after it.
// Synchronous reset restores all slots to 07:00 hidden and clears the result; no clearing pass.
// The response cannot be stalled: it is shown for exactly one cycle.
`default_nettype none

module weekly_alarm_next_selector_unit #(
   parameter int ALARM_SLOTS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire wans_pkg::req_type req_word,
   output logic                   rsp_valid,
   output wans_pkg::rsp_type      rsp_word,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_wdata
);

   localparam int CNT_W = $clog2(ALARM_SLOTS + 1);

   wans_pkg::state_type    state_ff;
   wans_pkg::state_type    state_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [7:0]             dur_ff;
   logic [2:0]             wday_ff;
   logic [10:0]            mins_ff;
   wans_pkg::cell_ctl_type ctl;
   wans_pkg::best_type     chain [ALARM_SLOTS + 1];
   wans_pkg::best_type     best;
   wans_pkg::op_type       op;
   logic                   accept;
   logic                   commit;
   logic [8:0]             end_sum;
   logic [4:0]             end_hsum;

   logic       armed_ff;
   logic [2:0] wday_out_ff;
   logic [4:0] hour_ff;
   logic [5:0] minute_ff;
   logic [4:0] end_hour_ff;
   logic [5:0] end_minute_ff;
   logic [2:0] slot_ff;

   assign op     = wans_pkg::op_type'(req_word.operation);
   assign accept = start && !busy;
   assign busy   = (state_ff != wans_pkg::ST_IDLE);

   // Configuration register: the wake-up duration.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff <= wans_pkg::DUR_RESET;
      end else if (csr_valid && csr_ready) begin
         dur_ff <= csr_wdata;
      end
   end

   // Capture the current time of an accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         wday_ff <= req_word.now_weekday;
         mins_ff <= 11'(11'(req_word.now_hour) * 11'd60) + 11'(req_word.now_minute);
      end
   end

   // Broadcast to the cells: slot writes and the one-shot disable land at the accepting edge.
   always_comb begin
      ctl.wr_stb           = accept && (op == wans_pkg::OP_WRITE);
      ctl.clr_stb          = accept && (op == wans_pkg::OP_TRIGGER);
      ctl.addr             = (op == wans_pkg::OP_WRITE) ? req_word.slot_index : slot_ff;
      ctl.wdata.hour       = wans_pkg::mod24(req_word.new_hour);
      ctl.wdata.minute     = wans_pkg::mod60({1'b0, req_word.new_minute});
      ctl.wdata.hidden     = req_word.new_hidden;
      ctl.wdata.enable     = req_word.new_enable;
      ctl.wdata.repeat_on  = req_word.new_repeat;
      ctl.wdata.day_mask   = req_word.new_day_mask;
      ctl.now_wday         = wday_ff;
      ctl.now_mins         = mins_ff;
   end

   // Row of cells, fed with an empty candidate at its head.
   always_comb begin
      chain[0]        = '0;
      chain[0].cand   = wans_pkg::CAND_NONE;
   end

   for (genvar i = 0; i < ALARM_SLOTS; i++) begin : g_cell
      wans_cell #(
         .INDEX(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .best_in (chain[i]),
         .best_out(chain[i + 1])
      );
   end

   assign best = chain[ALARM_SLOTS];

   // Sequencer: state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wans_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Sequencer: next state, row fill count and commit strobe.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      commit   = 1'b0;
      case (state_ff)
         wans_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               if ((op == wans_pkg::OP_FIND) || (op == wans_pkg::OP_TRIGGER)) begin
                  state_in = wans_pkg::ST_SEARCH;
               end else begin
                  state_in = wans_pkg::ST_RESPOND;
               end
            end
         end
         wans_pkg::ST_SEARCH: begin
            if (cnt_ff == CNT_W'(ALARM_SLOTS)) begin
               commit   = 1'b1;
               state_in = wans_pkg::ST_RESPOND;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         wans_pkg::ST_RESPOND: begin
            state_in = wans_pkg::ST_IDLE;
         end
         default: begin
            state_in = wans_pkg::ST_IDLE;
         end
      endcase
   end

   // End of the wake-up period: alarm time plus duration, wrapped to the day.
   assign end_sum  = 9'(best.minute) + 9'(dur_ff);
   assign end_hsum = best.hour + 5'(wans_pkg::div60(end_sum));

   // Result registers: a miss clears only the armed flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         wday_out_ff   <= '0;
         hour_ff       <= '0;
         minute_ff     <= '0;
         end_hour_ff   <= '0;
         end_minute_ff <= '0;
         slot_ff       <= '0;
      end else if (commit) begin
         armed_ff <= best.found;
         if (best.found) begin
            wday_out_ff   <= best.day + 3'd1;
            hour_ff       <= best.hour;
            minute_ff     <= best.minute;
            end_minute_ff <= wans_pkg::mod60(end_sum);
            end_hour_ff   <= (end_hsum >= 5'(wans_pkg::HOURS_PER_DAY)) ?
                             end_hsum - 5'(wans_pkg::HOURS_PER_DAY) : end_hsum;
            slot_ff       <= best.slot;
         end
      end
   end

   // Response word always shows the held result; the strobe marks it.
   assign rsp_valid              = (state_ff == wans_pkg::ST_RESPOND);
   assign rsp_word.alarm_armed   = armed_ff;
   assign rsp_word.alarm_weekday = wday_out_ff;
   assign rsp_word.alarm_hour    = hour_ff;
   assign rsp_word.alarm_minute  = minute_ff;
   assign rsp_word.end_hour      = end_hour_ff;
   assign rsp_word.end_minute    = end_minute_ff;
   assign rsp_word.chosen_slot   = slot_ff;

   // An accepted word keeps the block busy in the next cycle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a word");

   // After the response strobe the block is free again.
   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after the response");

   // An armed result always names a weekday.
   a_armed_day : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.alarm_armed) |-> (rsp_word.alarm_weekday != 3'd0))
      else $error("armed result without a weekday");

   // Reported times stay within the day.
   a_time_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_word.alarm_hour < 5'd24) && (rsp_word.end_hour < 5'd24) &&
                     (rsp_word.alarm_minute < 6'd60) && (rsp_word.end_minute < 6'd60)))
      else $error("reported time out of range");

   // The fill count never runs past the row length.
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == wans_pkg::ST_SEARCH) |-> (cnt_ff <= CNT_W'(ALARM_SLOTS)))
      else $error("row fill count overran");

endmodule

`default_nettype wire
